[hdl/apc_pkg.sv]
// shared types and constants for the alarm panel controller
package apc_pkg;

	// panel modes
	typedef enum logic [2:0] {
		MODE_DISARMED   = 3'd0,
		MODE_ARMED_HOME = 3'd1,
		MODE_ARMED_AWAY = 3'd2,
		MODE_PENDING    = 3'd3,
		MODE_TRIGGERED  = 3'd4,
		MODE_ARMING     = 3'd5
	} mode_t;

	// item kinds
	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_COMMAND = 1'b1;

	// command codes
	localparam logic [1:0] CMD_DISARM   = 2'd0;
	localparam logic [1:0] CMD_ARM_HOME = 2'd1;
	localparam logic [1:0] CMD_ARM_AWAY = 2'd2;
	localparam logic [1:0] CMD_IGNORED  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_ENTRY_DELAY = 2'd0;
	localparam logic [1:0] REG_EXIT_DELAY  = 2'd1;
	localparam logic [1:0] REG_TICK_MS     = 2'd2;
	localparam logic [1:0] REG_SIREN_LOW   = 2'd3;

	// configuration reset values
	localparam logic [31:0] ENTRY_DELAY_RST = 32'd30000;
	localparam logic [31:0] EXIT_DELAY_RST  = 32'd30000;
	localparam logic [15:0] TICK_MS_RST     = 16'd100;

	// timer saturation value
	localparam logic [31:0] TIMER_MAX = 32'hFFFF_FFFF;

	// input transaction
	typedef struct packed {
		logic       kind;
		logic [1:0] command;
		logic       door_sense;
		logic       motion_seen;
	} req_t;

	// result transaction
	typedef struct packed {
		logic [2:0] alarm_mode;
		logic       mode_report;
		logic       siren_level;
		logic       door_report;
		logic       motion_report;
		logic       door_level;
		logic       motion_level;
	} rsp_t;

	// configuration registers as seen by the core
	typedef struct packed {
		logic [31:0] entry_wait_ms;
		logic [31:0] exit_wait_ms;
		logic [15:0] tick_ms;
		logic        siren_invert;
	} cfg_t;

endpackage

[hdl/alarm_panel_controller.sv]
// alarm panel controller top level: config registers, stages and result register
//
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  apc_pkg::req_t req
// rsp      out        rsp_valid / rsp_stall  apc_pkg::rsp_t rsp
// cfg      in         cfg_we                 cfg_index, cfg_data
//
// one transaction per cycle sustained while the result is not stalled; a result
// is offered once its request has passed the input register, then the result register.
// the mode update, the saturating timer add and the delay compares sit
// between those two registers.
// reset clears mode, timer and sensor history; config registers take reset values.
// a stalled result holds back the input register; at most one more request
// is taken while the result waits, then req_stall rises.
module alarm_panel_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  apc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output apc_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	import apc_pkg::*;

	cfg_t cfg_q;
	logic advance, fire, valid_s1, rsp_valid_q;
	req_t item_s1;
	rsp_t result, rsp_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_wait_ms <= ENTRY_DELAY_RST;
			cfg_q.exit_wait_ms  <= EXIT_DELAY_RST;
			cfg_q.tick_ms       <= TICK_MS_RST;
			cfg_q.siren_invert  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_DELAY: cfg_q.entry_wait_ms <= cfg_data;
				REG_EXIT_DELAY:  cfg_q.exit_wait_ms  <= cfg_data;
				REG_TICK_MS:     cfg_q.tick_ms       <= cfg_data[15:0];
				REG_SIREN_LOW:   cfg_q.siren_invert  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// the result register can take a new transaction
	assign advance = !rsp_valid_q || !rsp_stall;
	assign fire    = valid_s1 && advance;

	apc_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	apc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// siren level follows the mode and the polarity setting
	a_siren: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp.siren_level ==
			((rsp.alarm_mode == MODE_TRIGGERED) ^ cfg_q.siren_invert))
		else $error("siren level does not match mode");

	// a command never reports sensor changes
	a_cmd_no_sensor: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.kind == KIND_COMMAND |=> !rsp.door_report && !rsp.motion_report)
		else $error("sensor report on command transaction");

	// an unrecognized command causes no transition
	a_ignored_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.kind == KIND_COMMAND && item_s1.command == CMD_IGNORED
		|=> !rsp.mode_report)
		else $error("ignored command reported a transition");

	// a held input transaction is not lost while the output is stalled
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage dropped a transaction");

endmodule

[hdl/apc_in_stage.sv]
// input register stage with stall toward the requester
module apc_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  apc_pkg::req_t req,
	input  logic          advance,
	output logic          valid_s1,
	output apc_pkg::req_t item_s1
);
	import apc_pkg::*;

	logic take;

	// stall only while the held item cannot move on
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= req;
		end
	end

endmodule

[hdl/apc_core.sv]
// mode state machine, phase timer and sensor change detection
module apc_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  apc_pkg::req_t item,
	input  apc_pkg::cfg_t cfg,
	output apc_pkg::rsp_t result
);
	import apc_pkg::*;

	mode_t       mode_q, mode_d;
	mode_t       goal_q, goal_d;
	logic [31:0] elapsed_q, elapsed_d;
	logic        door_seen_q, door_lvl_q, motion_seen_q, motion_lvl_q;
	logic        door_chg, motion_chg;
	logic        moved;
	logic [32:0] sum;
	logic [31:0] timer;
	logic        is_tick;

	assign is_tick = (item.kind == KIND_TICK);

	// saturating timer advance
	assign sum   = {1'b0, elapsed_q} + {17'd0, cfg.tick_ms};
	assign timer = sum[32] ? TIMER_MAX : sum[31:0];

	// sensor change detection, first sample always counts
	assign door_chg   = is_tick && (!door_seen_q || (door_lvl_q != item.door_sense));
	assign motion_chg = is_tick && (!motion_seen_q || (motion_lvl_q != item.motion_seen));

	// next state
	always_comb begin
		mode_d = mode_q;
		goal_d = goal_q;
		moved  = 1'b0;
		elapsed_d = elapsed_q;
		if (!is_tick) begin
			case (item.command)
				CMD_DISARM: begin
					mode_d = MODE_DISARMED;
					moved  = 1'b1;
				end
				CMD_ARM_HOME: begin
					goal_d = MODE_ARMED_HOME;
					mode_d = MODE_ARMED_HOME;
					moved  = 1'b1;
				end
				CMD_ARM_AWAY: begin
					goal_d = MODE_ARMED_AWAY;
					mode_d = MODE_ARMING;
					moved  = 1'b1;
				end
				default: begin
				end
			endcase
		end else begin
			elapsed_d = timer;
			case (mode_q)
				MODE_ARMING: begin
					if (timer >= cfg.exit_wait_ms) begin
						mode_d = goal_q;
						moved  = 1'b1;
					end
				end
				MODE_ARMED_AWAY: begin
					if (item.door_sense || item.motion_seen) begin
						goal_d = MODE_ARMED_AWAY;
						mode_d = MODE_PENDING;
						moved  = 1'b1;
					end
				end
				MODE_ARMED_HOME: begin
					if (item.door_sense) begin
						goal_d = MODE_ARMED_HOME;
						mode_d = MODE_PENDING;
						moved  = 1'b1;
					end
				end
				MODE_PENDING: begin
					if (timer >= cfg.entry_wait_ms) begin
						mode_d = MODE_TRIGGERED;
						moved  = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		// every transition restarts the phase timer
		if (moved) begin
			elapsed_d = '0;
		end
	end

	// result fields
	always_comb begin
		result.alarm_mode    = mode_d;
		result.mode_report   = moved;
		result.siren_level   = (mode_d == MODE_TRIGGERED) ^ cfg.siren_invert;
		result.door_report   = door_chg;
		result.motion_report = motion_chg;
		result.door_level    = is_tick ? item.door_sense : door_lvl_q;
		result.motion_level  = is_tick ? item.motion_seen : motion_lvl_q;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_DISARMED;
			goal_q        <= MODE_DISARMED;
			elapsed_q     <= '0;
			door_seen_q   <= 1'b0;
			door_lvl_q    <= 1'b0;
			motion_seen_q <= 1'b0;
			motion_lvl_q  <= 1'b0;
		end else if (fire) begin
			mode_q    <= mode_d;
			goal_q    <= goal_d;
			elapsed_q <= elapsed_d;
			if (is_tick) begin
				door_seen_q   <= 1'b1;
				door_lvl_q    <= item.door_sense;
				motion_seen_q <= 1'b1;
				motion_lvl_q  <= item.motion_seen;
			end
		end
	end

endmodule

[dv/tb.sv]
// testbench for the alarm panel controller: self-checking stimulus, predictor and scoreboard
import apc_pkg::*;

// predicts each result from its request and checks the results in order
class panel_scoreboard;
	logic [31:0] entry_delay;
	logic [31:0] exit_delay;
	logic [15:0] tick_len;
	logic        siren_low;
	mode_t       mode;
	mode_t       arm_goal;
	logic [31:0] elapsed;
	logic [1:0]  door_hist;
	logic [1:0]  motion_hist;
	rsp_t        awaited_results[$];
	int          errors;

	function new();
		entry_delay = ENTRY_DELAY_RST;
		exit_delay = EXIT_DELAY_RST;
		tick_len = TICK_MS_RST;
		siren_low = 1'b0;
		mode = MODE_DISARMED;
		arm_goal = MODE_DISARMED;
		elapsed = '0;
		door_hist = 2'b00;
		motion_hist = 2'b00;
		errors = 0;
	endfunction

	// mirror of a register write
	function void set_reg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			REG_ENTRY_DELAY: entry_delay = data;
			REG_EXIT_DELAY:  exit_delay = data;
			REG_TICK_MS:     tick_len = data[15:0];
			default:         siren_low = data[0];
		endcase
	endfunction

	// works out the result of one accepted request transaction
	function void note_request(req_t r);
		rsp_t        res;
		logic        moved;
		logic [32:0] sum;
		res = '0;
		moved = 1'b0;
		if (r.kind == KIND_COMMAND) begin
			case (r.command)
				CMD_DISARM: begin
					mode = MODE_DISARMED;
					moved = 1'b1;
				end
				CMD_ARM_HOME: begin
					arm_goal = MODE_ARMED_HOME;
					mode = MODE_ARMED_HOME;
					moved = 1'b1;
				end
				CMD_ARM_AWAY: begin
					arm_goal = MODE_ARMED_AWAY;
					mode = MODE_ARMING;
					moved = 1'b1;
				end
				default: ;
			endcase
		end else begin
			// saturating phase timer
			sum = {1'b0, elapsed} + {17'd0, tick_len};
			elapsed = sum[32] ? TIMER_MAX : sum[31:0];
			// sensor sampling, first sample always reported
			if (door_hist != {1'b1, r.door_sense}) begin
				door_hist = {1'b1, r.door_sense};
				res.door_report = 1'b1;
			end
			if (motion_hist != {1'b1, r.motion_seen}) begin
				motion_hist = {1'b1, r.motion_seen};
				res.motion_report = 1'b1;
			end
			// mode rules on a tick
			case (mode)
				MODE_ARMING: begin
					if (elapsed >= exit_delay) begin
						mode = arm_goal;
						moved = 1'b1;
					end
				end
				MODE_ARMED_AWAY: begin
					if (r.door_sense || r.motion_seen) begin
						arm_goal = MODE_ARMED_AWAY;
						mode = MODE_PENDING;
						moved = 1'b1;
					end
				end
				MODE_ARMED_HOME: begin
					if (r.door_sense) begin
						arm_goal = MODE_ARMED_HOME;
						mode = MODE_PENDING;
						moved = 1'b1;
					end
				end
				MODE_PENDING: begin
					if (elapsed >= entry_delay) begin
						mode = MODE_TRIGGERED;
						moved = 1'b1;
					end
				end
				default: ;
			endcase
		end
		// any transition restarts the phase timer
		if (moved)
			elapsed = '0;
		res.alarm_mode = mode;
		res.mode_report = moved;
		res.siren_level = (mode == MODE_TRIGGERED) ^ siren_low;
		res.door_level = door_hist[0];
		res.motion_level = motion_hist[0];
		awaited_results.push_back(res);
	endfunction

	function void compare_field(string field, logic [2:0] want, logic [2:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endfunction

	// compares one accepted result transaction with the oldest prediction
	function void check_result(rsp_t got);
		rsp_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, got %p", $time, got);
			errors++;
			return;
		end
		want = awaited_results.pop_front();
		compare_field("alarm_mode", want.alarm_mode, got.alarm_mode);
		compare_field("mode_report", want.mode_report, got.mode_report);
		compare_field("siren_level", want.siren_level, got.siren_level);
		compare_field("door_report", want.door_report, got.door_report);
		compare_field("motion_report", want.motion_report, got.motion_report);
		compare_field("door_level", want.door_level, got.door_level);
		compare_field("motion_level", want.motion_level, got.motion_level);
	endfunction
endclass

module tb;
	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_t        rsp;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	panel_scoreboard panel_sb;
	req_t            stim_q[$];

	alarm_panel_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#(12 * 4_000_000);
		$display("TEST FAILED");
		$finish;
	end

	// monitor both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				panel_sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				panel_sb.check_result(rsp);
		end
	end

	// result stall pattern with occasional long hold-offs
	initial begin
		int seg_len;
		int stall_style;
		int since_hold;
		rsp_stall = 1'b0;
		since_hold = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (since_hold > 400 || $urandom_range(0, 29) == 0) begin
				// long hold so the block fills up and stalls its input
				rsp_stall <= 1'b1;
				repeat ($urandom_range(40, 80)) @(posedge clk);
				since_hold = 0;
			end else begin
				seg_len = $urandom_range(4, 40);
				stall_style = $urandom_range(0, 3);
				repeat (seg_len) begin
					case (stall_style)
						0: rsp_stall <= 1'b0;
						1: rsp_stall <= ($urandom_range(0, 3) == 0);
						2: rsp_stall <= ($urandom_range(0, 3) != 0);
						default: rsp_stall <= 1'($urandom_range(0, 1));
					endcase
					@(posedge clk);
				end
				since_hold += seg_len;
			end
		end
	end

	function automatic req_t command_item(logic [1:0] code);
		req_t item;
		item.kind = KIND_COMMAND;
		item.command = code;
		item.door_sense = 1'($urandom_range(0, 1));
		item.motion_seen = 1'($urandom_range(0, 1));
		return item;
	endfunction

	function automatic req_t tick_item(logic door, logic motion);
		req_t item;
		item.kind = KIND_TICK;
		item.command = 2'($urandom_range(0, 3));
		item.door_sense = door;
		item.motion_seen = motion;
		return item;
	endfunction

	function automatic req_t noise_item();
		logic [4:0] bits;
		bits = 5'($urandom);
		return req_t'(bits);
	endfunction

	// ticks needed to cover a delay, capped so long delays stay cheap
	function automatic int ticks_for(logic [31:0] delay_ms);
		if (panel_sb.tick_len == 0)
			return $urandom_range(1, 4);
		if (delay_ms / panel_sb.tick_len > 30)
			return $urandom_range(1, 30);
		return delay_ms / panel_sb.tick_len + $urandom_range(0, 2);
	endfunction

	// one arm / trip / alarm / disarm sequence, or a short burst of noise
	function automatic void add_scenario();
		int   n;
		logic away;
		if ($urandom_range(0, 9) >= 8) begin
			repeat ($urandom_range(1, 8)) stim_q.push_back(noise_item());
			return;
		end
		away = ($urandom_range(0, 9) < 6);
		stim_q.push_back(command_item(away ? CMD_ARM_AWAY : CMD_ARM_HOME));
		n = away ? ticks_for(panel_sb.exit_delay) : $urandom_range(0, 2);
		repeat (n) stim_q.push_back(tick_item(1'b0, 1'b0));
		// trip attempt; motion alone does not trip armed home
		if (away) begin
			case ($urandom_range(0, 2))
				0: stim_q.push_back(tick_item(1'b1, 1'b0));
				1: stim_q.push_back(tick_item(1'b0, 1'b1));
				default: stim_q.push_back(tick_item(1'b1, 1'b1));
			endcase
		end else begin
			stim_q.push_back(tick_item($urandom_range(0, 4) != 0,
				1'($urandom_range(0, 1))));
		end
		n = ticks_for(panel_sb.entry_delay) + $urandom_range(0, 2);
		repeat (n) stim_q.push_back(tick_item(1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1))));
		if ($urandom_range(0, 4) != 0)
			stim_q.push_back(command_item(CMD_DISARM));
	endfunction

	// offer one request transaction and hold it until taken
	task automatic send_item(input req_t item);
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
	endtask

	// send the queued requests in bursts with random gaps
	task automatic drive_queue();
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 12);
		while (stim_q.size() > 0) begin
			send_item(stim_q.pop_front());
			burst_left--;
			if (burst_left == 0 && stim_q.size() > 0) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 12);
			end
		end
	endtask

	// let every outstanding result drain
	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (panel_sb.awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		panel_sb.set_reg(idx, data);
	endtask

	task automatic program_panel(input logic [31:0] entry_ms, input logic [31:0] exit_ms,
			input logic [15:0] tick_len, input logic siren_low);
		write_reg(REG_ENTRY_DELAY, entry_ms);
		write_reg(REG_EXIT_DELAY, exit_ms);
		write_reg(REG_TICK_MS, {16'd0, tick_len});
		write_reg(REG_SIREN_LOW, {31'd0, siren_low});
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] entry_ms, input logic [31:0] exit_ms,
			input logic [15:0] tick_len, input logic siren_low, input int n_items);
		program_panel(entry_ms, exit_ms, tick_len, siren_low);
		while (stim_q.size() < n_items)
			add_scenario();
		drive_queue();
		wait_idle();
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ENTRY_DELAY;
		cfg_data = '0;
		panel_sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed checks with the reset configuration
		stim_q.push_back(command_item(CMD_IGNORED));
		stim_q.push_back(command_item(CMD_DISARM));
		stim_q.push_back(tick_item(1'b1, 1'b0));
		stim_q.push_back(tick_item(1'b1, 1'b1));
		stim_q.push_back(tick_item(1'b0, 1'b0));
		stim_q.push_back(command_item(CMD_ARM_HOME));
		stim_q.push_back(command_item(CMD_ARM_HOME));
		stim_q.push_back(tick_item(1'b0, 1'b1));
		stim_q.push_back(tick_item(1'b1, 1'b0));
		stim_q.push_back(tick_item(1'b1, 1'b1));
		stim_q.push_back(command_item(CMD_ARM_AWAY));
		stim_q.push_back(tick_item(1'b1, 1'b1));
		stim_q.push_back(command_item(CMD_ARM_AWAY));
		stim_q.push_back(command_item(CMD_IGNORED));
		stim_q.push_back(command_item(CMD_DISARM));
		stim_q.push_back(tick_item(1'b0, 1'b0));
		repeat (4) stim_q.push_back(noise_item());
		drive_queue();
		wait_idle();

		// random sequences over several settings
		run_phase(32'd300, 32'd500, 16'd100, 1'b0, 450);
		run_phase(32'd0, 32'd0, 16'd1, 1'b1, 350);
		run_phase(32'd1, 32'd1, 16'd0, 1'b1, 200);
		run_phase(32'd131070, 32'd65535, 16'hFFFF, 1'b1, 300);

		// very long delays: arming holds while the timer is far below the limit
		program_panel(TIMER_MAX, TIMER_MAX, 16'hFFFE, 1'b0);
		stim_q.push_back(command_item(CMD_ARM_AWAY));
		repeat (30) stim_q.push_back(tick_item(1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1))));
		stim_q.push_back(command_item(CMD_DISARM));
		drive_queue();
		wait_idle();

		if (panel_sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
